// ===== rtl/core/rat_pkg.sv =====
// Package for the range address translation table.
// Holds the request and status codes and the table entry layout.
// No dependencies.
`default_nettype none

package rat_pkg;

  localparam int unsigned ADDR_W = 64;

  // Request opcodes.
  localparam logic [1:0] OP_BEGIN     = 2'd0;
  localparam logic [1:0] OP_ADD       = 2'd1;
  localparam logic [1:0] OP_COMMIT    = 2'd2;
  localparam logic [1:0] OP_TRANSLATE = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // One table entry covers the guest bytes [g_start, g_end).
  typedef struct packed {
    logic [ADDR_W-1:0] g_start;
    logic [ADDR_W-1:0] g_end;
    logic [ADDR_W-1:0] h_start;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/rat_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read. No dependencies.
`default_nettype none

module rat_ram #(
  parameter int unsigned WIDTH = 192,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/range_address_translation_table_top.sv =====
// Range address translation table with a shadow bank and move-to-front lookup.
// Depends on rat_pkg and rat_ram; both banks live in one rat_ram instance.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid / in_stall | opcode, guest_addr, byte_count, host_base, is_ram
//   out_    | output    | out_valid/out_stall | host_addr, status
//
// Begin, commit, a non-RAM add and an add into an empty shadow bank go straight
// to the result; any other add first reads the last shadow entry and then merges,
// appends or reports full. A translate on an empty active bank is answered as a
// miss; otherwise the scan reads one entry per cycle from the table memory, and a
// hit then passes through the front swap and the sum before its result.
// One request is in work at a time; the next is taken while a result waits.
// Reset clears the control state, counts and bank select; commit swaps banks, so no
// clearing pass or copy sweep is needed. A stalled result holds in its register.
`default_nettype none

module range_address_translation_table_top
  import rat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_guest_addr,
  input  wire logic [ADDR_W-1:0] in_byte_count,
  input  wire logic [ADDR_W-1:0] in_host_base,
  input  wire logic              in_is_ram,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [ADDR_W-1:0] out_host_addr,
  output logic      [1:0]        out_status
);

  localparam int unsigned IW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RAM_DEPTH = 2 ** (IW + 1);
  localparam int unsigned EW        = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_SCAN,
    ST_OFFSET,
    ST_SWAP,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              active_bank_r, active_bank_nxt;
  logic [CW-1:0]     active_count_r, active_count_nxt;
  logic [CW-1:0]     shadow_count_r, shadow_count_nxt;
  logic [ADDR_W-1:0] req_addr_r, req_addr_nxt;
  logic [ADDR_W-1:0] req_end_r, req_end_nxt;
  logic [ADDR_W-1:0] req_host_r, req_host_nxt;
  logic              req_carry_r, req_carry_nxt;
  entry_t            ent_r, ent_nxt;
  entry_t            ent0_r, ent0_nxt;
  logic [ADDR_W-1:0] calc_r, calc_nxt;
  logic [CW-1:0]     issue_idx_r, issue_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [ADDR_W-1:0] res_host_r, res_host_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_host_r, out_host_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              ram_we, ram_re;
  logic [IW:0]       ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [EW-1:0]     ram_rdata;
  entry_t            rd_ent;

  logic [ADDR_W:0]   in_sum;
  logic [IW-1:0]     shadow_last;
  logic              entry_hit;
  logic              merge_ok;

  assign in_sum      = {1'b0, in_guest_addr} + {1'b0, in_byte_count};
  assign shadow_last = IW'(shadow_count_r - CW'(1));
  assign rd_ent      = entry_t'(ram_rdata);

  // Containment test against the entry just read from the active bank.
  assign entry_hit = !req_carry_r && (rd_ent.g_start <= req_addr_r) &&
                     (req_end_r <= rd_ent.g_end);

  // Merge test: the new region continues the last shadow entry in both spaces.
  assign merge_ok = (req_addr_r == ent_r.g_end) && (req_host_r == ent_r.h_start + calc_r);

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_host_addr = out_host_r;
  assign out_status    = out_status_r;

  // Next-state and datapath control.
  always_comb begin
    state_nxt        = state_r;
    active_bank_nxt  = active_bank_r;
    active_count_nxt = active_count_r;
    shadow_count_nxt = shadow_count_r;
    req_addr_nxt     = req_addr_r;
    req_end_nxt      = req_end_r;
    req_host_nxt     = req_host_r;
    req_carry_nxt    = req_carry_r;
    ent_nxt          = ent_r;
    ent0_nxt         = ent0_r;
    calc_nxt         = calc_r;
    issue_idx_nxt    = issue_idx_r;
    pend_nxt         = 1'b0;
    pend_idx_nxt     = pend_idx_r;
    hit_idx_nxt      = hit_idx_r;
    res_host_nxt     = res_host_r;
    res_status_nxt   = res_status_r;
    out_host_nxt     = out_host_r;
    out_status_nxt   = out_status_r;
    out_valid_nxt    = out_valid_r && out_stall;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_addr_nxt   = in_guest_addr;
          req_end_nxt    = in_sum[ADDR_W-1:0];
          req_carry_nxt  = in_sum[ADDR_W];
          req_host_nxt   = in_host_base;
          res_host_nxt   = '0;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_DONE;
          unique case (in_opcode)
            OP_BEGIN: begin
              shadow_count_nxt = '0;
            end
            OP_ADD: begin
              if (in_is_ram) begin
                if (shadow_count_r == '0) begin
                  // Empty shadow bank: write the first entry straight away.
                  ram_we           = 1'b1;
                  ram_waddr        = {~active_bank_r, IW'(0)};
                  ram_wdata        = '{g_start: in_guest_addr,
                                       g_end:   in_sum[ADDR_W-1:0],
                                       h_start: in_host_base};
                  shadow_count_nxt = CW'(1);
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = {~active_bank_r, shadow_last};
                  state_nxt = ST_ADD_RD;
                end
              end
            end
            OP_COMMIT: begin
              active_bank_nxt  = ~active_bank_r;
              active_count_nxt = shadow_count_r;
              shadow_count_nxt = '0;
            end
            OP_TRANSLATE: begin
              if (active_count_r == '0) begin
                res_status_nxt = STATUS_MISS;
              end else begin
                issue_idx_nxt = '0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_ADD_RD: begin
        ent_nxt   = rd_ent;
        calc_nxt  = rd_ent.g_end - rd_ent.g_start;
        state_nxt = ST_ADD_CMP;
      end

      ST_ADD_CMP: begin
        state_nxt = ST_DONE;
        if (merge_ok) begin
          ram_we    = 1'b1;
          ram_waddr = {~active_bank_r, shadow_last};
          ram_wdata = '{g_start: ent_r.g_start, g_end: req_end_r, h_start: ent_r.h_start};
        end else if (shadow_count_r == CW'(TABLE_DEPTH)) begin
          res_status_nxt = STATUS_FULL;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = {~active_bank_r, shadow_count_r[IW-1:0]};
          ram_wdata        = '{g_start: req_addr_r, g_end: req_end_r, h_start: req_host_r};
          shadow_count_nxt = shadow_count_r + CW'(1);
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; compare the entry issued in the previous cycle.
        if (issue_idx_r < active_count_r) begin
          ram_re        = 1'b1;
          ram_raddr     = {active_bank_r, issue_idx_r[IW-1:0]};
          issue_idx_nxt = issue_idx_r + CW'(1);
          pend_nxt      = 1'b1;
          pend_idx_nxt  = issue_idx_r[IW-1:0];
        end
        if (pend_r) begin
          if (pend_idx_r == '0) begin
            ent0_nxt = rd_ent;
          end
          if (entry_hit) begin
            ent_nxt     = rd_ent;
            hit_idx_nxt = pend_idx_r;
            pend_nxt    = 1'b0;
            state_nxt   = ST_OFFSET;
          end else if ((CW'(pend_idx_r) + CW'(1)) == active_count_r) begin
            res_host_nxt   = '0;
            res_status_nxt = STATUS_MISS;
            pend_nxt       = 1'b0;
            state_nxt      = ST_DONE;
          end
        end
      end

      ST_OFFSET: begin
        // Move the hit entry to the front.
        calc_nxt = req_addr_r - ent_r.g_start;
        if (hit_idx_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = {active_bank_r, IW'(0)};
          ram_wdata = ent_r;
        end
        state_nxt = ST_SWAP;
      end

      ST_SWAP: begin
        // The old front entry takes the hit entry's place.
        if (hit_idx_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = {active_bank_r, hit_idx_r};
          ram_wdata = ent0_r;
        end
        res_host_nxt   = ent_r.h_start + calc_r;
        res_status_nxt = STATUS_OK;
        state_nxt      = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_host_nxt   = res_host_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      active_bank_r  <= 1'b0;
      active_count_r <= '0;
      shadow_count_r <= '0;
      pend_r         <= 1'b0;
      issue_idx_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      active_bank_r  <= active_bank_nxt;
      active_count_r <= active_count_nxt;
      shadow_count_r <= shadow_count_nxt;
      pend_r         <= pend_nxt;
      issue_idx_r    <= issue_idx_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    req_addr_r   <= req_addr_nxt;
    req_end_r    <= req_end_nxt;
    req_host_r   <= req_host_nxt;
    req_carry_r  <= req_carry_nxt;
    ent_r        <= ent_nxt;
    ent0_r       <= ent0_nxt;
    calc_r       <= calc_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_host_r   <= res_host_nxt;
    res_status_r <= res_status_nxt;
    out_host_r   <= out_host_nxt;
    out_status_r <= out_status_nxt;
  end

  // Both banks share one memory; the bank select is the top address bit.
  rat_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The counts never exceed the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    (active_count_r <= CW'(TABLE_DEPTH)) && (shadow_count_r <= CW'(TABLE_DEPTH)))
    else $error("table count beyond depth");

  // The sequencer never reads and writes the memory in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("table memory read and write overlap");

  // A pending compare always refers to an entry below the active count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> ((CW'(pend_idx_r) + CW'(1)) <= active_count_r))
    else $error("scan compare beyond active count");

  // A new result is loaded only when the previous one has gone or is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result overwritten while stalled");

  // A full status only ever answers an add request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (res_status_nxt == STATUS_OK || res_status_nxt == STATUS_MISS))
    else $error("full status raised during a translate");

endmodule

`default_nettype wire

// ===== tb/rat_scoreboard_pkg.sv =====
// Scoreboard for the range address translation table testbench.
// Holds a predictor of both table banks and the queue of awaited replies.
// Depends on rat_pkg for the opcodes, status codes and address width.
`default_nettype none

package rat_scoreboard_pkg;
  import rat_pkg::*;

  localparam int unsigned TB_TABLE_DEPTH = 16;

  typedef struct packed {
    logic [ADDR_W-1:0] host_addr;
    logic [1:0]        status;
  } reply_t;

  class translation_scoreboard;
    // Active bank: entry k covers guest bytes [act_lo[k], act_hi[k]).
    logic [ADDR_W-1:0] act_lo   [TB_TABLE_DEPTH];
    logic [ADDR_W-1:0] act_hi   [TB_TABLE_DEPTH];
    logic [ADDR_W-1:0] act_host [TB_TABLE_DEPTH];
    int unsigned       act_used;
    // Shadow bank being rebuilt.
    logic [ADDR_W-1:0] shd_lo   [TB_TABLE_DEPTH];
    logic [ADDR_W-1:0] shd_hi   [TB_TABLE_DEPTH];
    logic [ADDR_W-1:0] shd_host [TB_TABLE_DEPTH];
    int unsigned       shd_used;

    reply_t awaited_replies[$];
    int     failures;

    function new();
      act_used = 0;
      shd_used = 0;
      failures = 0;
    endfunction

    // Appends a region to the shadow bank, or extends the last entry when the
    // region continues it in both guest and host space.
    function logic [1:0] append_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] len,
                                       logic [ADDR_W-1:0] host);
      int unsigned       t;
      logic [ADDR_W-1:0] last_len;
      if (shd_used > 0) begin
        t = shd_used - 1;
        last_len = shd_hi[t] - shd_lo[t];
        if (lo == shd_hi[t] && host == shd_host[t] + last_len) begin
          shd_hi[t] = lo + len;
          return STATUS_OK;
        end
      end
      if (shd_used >= TB_TABLE_DEPTH) return STATUS_FULL;
      shd_lo[shd_used]   = lo;
      shd_hi[shd_used]   = lo + len;
      shd_host[shd_used] = host;
      shd_used++;
      return STATUS_OK;
    endfunction

    // Looks an access up in the active bank; a hit beyond entry 0 is swapped
    // to the front before the host address is formed.
    function logic [1:0] lookup(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len,
                                output logic [ADDR_W-1:0] host);
      logic [ADDR_W:0]   span;
      logic [ADDR_W-1:0] hi;
      int                hit;
      logic [ADDR_W-1:0] tmp_lo;
      logic [ADDR_W-1:0] tmp_hi;
      logic [ADDR_W-1:0] tmp_host;
      host = '0;
      span = {1'b0, addr} + {1'b0, len};
      hi   = span[ADDR_W-1:0];
      if (act_used == 0 || span[ADDR_W]) return STATUS_MISS;
      hit = -1;
      for (int k = 0; k < act_used; k++) begin
        if (act_lo[k] <= addr && hi <= act_hi[k]) begin
          hit = k;
          break;
        end
      end
      if (hit < 0) return STATUS_MISS;
      if (hit != 0) begin
        tmp_lo = act_lo[hit];
        tmp_hi = act_hi[hit];
        tmp_host = act_host[hit];
        act_lo[hit] = act_lo[0];
        act_hi[hit] = act_hi[0];
        act_host[hit] = act_host[0];
        act_lo[0] = tmp_lo;
        act_hi[0] = tmp_hi;
        act_host[0] = tmp_host;
      end
      host = act_host[0] + (addr - act_lo[0]);
      return STATUS_OK;
    endfunction

    // Predicts the reply to an accepted request and queues it.
    function void note_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] len, logic [ADDR_W-1:0] hbase, logic ram);
      reply_t r;
      r.host_addr = '0;
      r.status = STATUS_OK;
      case (op)
        OP_BEGIN: begin
          shd_used = 0;
        end
        OP_ADD: begin
          if (ram) r.status = append_region(addr, len, hbase);
        end
        OP_COMMIT: begin
          act_lo = shd_lo;
          act_hi = shd_hi;
          act_host = shd_host;
          act_used = shd_used;
          shd_used = 0;
        end
        OP_TRANSLATE: begin
          r.status = lookup(addr, len, r.host_addr);
        end
      endcase
      awaited_replies.push_back(r);
    endfunction

    // Compares a delivered reply with the oldest prediction.
    function void check_reply(logic [ADDR_W-1:0] host_addr, logic [1:0] status);
      reply_t exp_r;
      if (awaited_replies.size() == 0) begin
        $error("reply with no request outstanding: host_addr %h status %0d",
               host_addr, status);
        failures++;
        return;
      end
      exp_r = awaited_replies.pop_front();
      if (host_addr !== exp_r.host_addr) begin
        $error("host_addr mismatch: expected %h, actual %h", exp_r.host_addr, host_addr);
        failures++;
      end
      if (status !== exp_r.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
        failures++;
      end
    endfunction

    function int outstanding();
      return awaited_replies.size();
    endfunction
  endclass

endpackage

`default_nettype wire

// ===== tb/tb_range_address_translation_table_top.sv =====
// Testbench for range_address_translation_table_top: directed rebuilds and
// lookups, then random rebuild/commit/translate sequences under back-pressure.
// Depends on rat_pkg and rat_scoreboard_pkg.
`default_nettype none

module tb_range_address_translation_table_top;
  import rat_pkg::*;
  import rat_scoreboard_pkg::*;

  localparam int TIMEOUT_UNITS = 1_000_000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int DRAIN_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_opcode;
  logic [ADDR_W-1:0] in_guest_addr;
  logic [ADDR_W-1:0] in_byte_count;
  logic [ADDR_W-1:0] in_host_base;
  logic              in_is_ram;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_host_addr;
  logic [1:0]        out_status;

  translation_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int requests_sent;

  range_address_translation_table_top #(
    .TABLE_DEPTH(TB_TABLE_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_guest_addr(in_guest_addr),
    .in_byte_count(in_byte_count),
    .in_host_base (in_host_base),
    .in_is_ram    (in_is_ram),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_host_addr(out_host_addr),
    .out_status   (out_status)
  );

  always #1 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one request from a falling edge and holds it until it is taken.
  task automatic send_request(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [ADDR_W-1:0] len, input logic [ADDR_W-1:0] hbase,
                              input logic ram);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_guest_addr <= addr;
    in_byte_count <= len;
    in_host_base  <= hbase;
    in_is_ram     <= ram;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, addr, len, hbase, ram);
    requests_sent++;
    @(negedge clk);
  endtask

  // Directed part: empty table, merging, a full shadow bank, lookups at edges.
  task automatic run_directed();
    logic [ADDR_W-1:0] lo;
    send_request(OP_TRANSLATE, 64'h1000, 64'h10, '0, 1'b0);
    send_request(OP_COMMIT, '0, '0, '0, 1'b0);
    send_request(OP_TRANSLATE, '1, '1, '1, 1'b1);
    send_request(OP_BEGIN, '1, '1, '1, 1'b1);
    send_request(OP_ADD, 64'h5000, 64'h100, 64'h7000, 1'b0);
    send_request(OP_ADD, 64'h1000, 64'h1000, 64'h8000_0000, 1'b1);
    send_request(OP_ADD, 64'h2000, 64'h800, 64'h8000_1000, 1'b1);
    for (int i = 1; i <= 13; i++) begin
      lo = i * 64'h10_0000;
      send_request(OP_ADD, lo, 64'h1000, 64'h4000_0000 + lo, 1'b1);
    end
    // A region running up to the top of the space ends at zero.
    send_request(OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 64'h9000_0000, 1'b1);
    send_request(OP_ADD, 64'h0100_0000_0000, 64'h1_0000, 64'hFFFF_FFFF_FFFF_8000, 1'b1);
    // The bank is now full: a new region is refused, a continuation still merges.
    send_request(OP_ADD, 64'h0200_0000_0000, 64'h10, '0, 1'b1);
    send_request(OP_ADD, 64'h0100_0001_0000, 64'h100, 64'h8000, 1'b1);
    send_request(OP_COMMIT, '0, '0, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'h1800, 64'h10, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'h40_0010, 64'h20, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'h1000, 64'h1800, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'h1000, 64'h1801, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_F800, 64'h10, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFF0, '1, '0, 1'b0);
    send_request(OP_TRANSLATE, 64'h0100_0000_C000, 64'h4, '0, 1'b0);
  endtask

  // One translate, mostly aimed inside a committed entry.
  task automatic issue_translate();
    int                r;
    int unsigned       k;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] sz;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 70 && sb.act_used > 0) begin
      k = $urandom_range(0, sb.act_used - 1);
      lo = sb.act_lo[k];
      sz = sb.act_hi[k] - lo;
      if (sz == 0) begin
        addr = lo;
        len = '0;
      end else begin
        off = rand64() % sz;
        addr = lo + off;
        case ($urandom_range(0, 3))
          0: len = '0;
          1: len = sz - off;
          default: len = rand64() % (sz - off);
        endcase
      end
    end else if (r < 80 && sb.act_used > 0) begin
      k = $urandom_range(0, sb.act_used - 1);
      addr = sb.act_hi[k] - ADDR_W'($urandom_range(0, 3));
      len = ADDR_W'($urandom_range(1, 8));
    end else if (r < 88) begin
      // The access end carries out of the address space.
      addr = rand64() | {1'b1, {(ADDR_W-1){1'b0}}};
      len = rand64() | {1'b1, {(ADDR_W-1){1'b0}}};
    end else begin
      addr = rand64();
      len = $urandom_range(0, 1) ? rand64() : ADDR_W'($urandom_range(0, 255));
    end
    send_request(OP_TRANSLATE, addr, len, rand64(), 1'($urandom_range(0, 1)));
  endtask

  // One region add: a continuation of the last entry, a non-RAM region or a
  // fresh region of mostly small size.
  task automatic issue_add();
    int                r;
    int unsigned       t;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] len;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: len = rand64();
      1: len = '0;
      default: len = ADDR_W'($urandom_range(1, 65535));
    endcase
    if (r < 25 && sb.shd_used > 0) begin
      t = sb.shd_used - 1;
      send_request(OP_ADD, sb.shd_hi[t], len, sb.shd_host[t] + (sb.shd_hi[t] - sb.shd_lo[t]),
                   1'b1);
    end else if (r < 32) begin
      send_request(OP_ADD, rand64(), rand64(), rand64(), 1'b0);
    end else begin
      case ($urandom_range(0, 9))
        0: lo = '0 - len;
        1: lo = ADDR_W'($urandom_range(0, 4096));
        default: lo = rand64();
      endcase
      send_request(OP_ADD, lo, len, rand64(), 1'b1);
    end
  endtask

  // A rebuild of the shadow bank, usually committed, then a run of lookups
  // with the odd request of random kind mixed in.
  task automatic run_episode();
    int n_adds;
    int n_lookups;
    if ($urandom_range(0, 9) != 0)
      send_request(OP_BEGIN, rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
    n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
    for (int i = 0; i < n_adds; i++) issue_add();
    if ($urandom_range(0, 9) != 0) send_request(OP_COMMIT, rand64(), rand64(), rand64(),
                                                1'($urandom_range(0, 1)));
    n_lookups = $urandom_range(4, 20);
    for (int i = 0; i < n_lookups; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(),
                     1'($urandom_range(0, 1)));
      else
        issue_translate();
    end
  endtask

  // Result side: random stall, plus one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Every reply taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_host_addr, out_status);
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_BEGIN;
    in_guest_addr = '0;
    in_byte_count = '0;
    in_host_base = '0;
    in_is_ram = 1'b0;
    send_idle_pct = 9;
    recv_stall_pct = 59;
    hold_off_cycles = 0;
    requests_sent = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    while (requests_sent < 170) run_episode();
    send_idle_pct = 59;
    recv_stall_pct = 9;
    while (requests_sent < 330) run_episode();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Hold the result side off while requests keep coming, so the block backs up.
    hold_off_cycles = HOLD_OFF_LEN;
    while (requests_sent < 490) run_episode();
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.outstanding() != 0) $error("%0d predicted replies never arrived", sb.outstanding());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_UNITS);
    $error("run did not complete in time");
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/rat_pkg.sv
rtl/core/rat_ram.sv
rtl/core/range_address_translation_table_top.sv
tb/rat_scoreboard_pkg.sv
tb/tb_range_address_translation_table_top.sv
